/* design/spf_pkg.sv */
// Package with the framing constants, the CRC-16 byte update and the frame entry type.
package spf_pkg;

  localparam int unsigned IndexWidth = 8;
  localparam int unsigned MaxBytes   = 10;
  localparam int unsigned CountWidth = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;
  localparam logic [7:0]  SYNC_A   = 8'hAA;
  localparam logic [7:0]  SYNC_B   = 8'h55;

  localparam logic [CountWidth-1:0] COUNT_MIDDLE = 4'd4;
  localparam logic [CountWidth-1:0] COUNT_LAST   = 4'd6;
  localparam logic [CountWidth-1:0] COUNT_FIRST  = 4'd8;
  localparam logic [CountWidth-1:0] COUNT_SINGLE = 4'd10;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountWidth-1:0]    count;
    logic                     pkt_end;
  } spf_entry_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/spf_packer.sv */
// Input stage that holds packet state and builds the bytes and CRC for one word.
module spf_packer #(
  parameter int unsigned WORDS_PER_PACKET = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,
  output logic               ent_valid,
  output spf_pkg::spf_entry_t ent,
  input  logic               ent_take
);
  import spf_pkg::*;

  logic [15:0]            sequence_count;
  logic [15:0]            running_crc;
  logic [IndexWidth-1:0]  word_index;

  logic                   first;
  logic                   last;
  logic [15:0]            crc_start;
  logic [15:0]            crc_seq;
  logic [15:0]            crc_word;
  spf_entry_t             ent_next;
  logic                   accept;

  assign s_tready = !ent_valid || ent_take;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    first = (word_index == '0);
    last  = ({1'b0, word_index} + 9'd1) >= 9'(WORDS_PER_PACKET);

    crc_start = first ? CRC_INIT : running_crc;
    crc_seq   = first ? crc_feed(crc_feed(crc_start, sequence_count[7:0]),
                                 sequence_count[15:8])
                      : crc_start;
    crc_word  = crc_feed(crc_feed(crc_feed(crc_feed(crc_seq, s_tdata[7:0]),
                         s_tdata[15:8]), s_tdata[23:16]), s_tdata[31:24]);

    ent_next         = '0;
    ent_next.pkt_end = last;
    if (first) begin
      ent_next.bytes[0] = SYNC_A;
      ent_next.bytes[1] = SYNC_B;
      ent_next.bytes[2] = sequence_count[7:0];
      ent_next.bytes[3] = sequence_count[15:8];
      ent_next.bytes[4] = s_tdata[7:0];
      ent_next.bytes[5] = s_tdata[15:8];
      ent_next.bytes[6] = s_tdata[23:16];
      ent_next.bytes[7] = s_tdata[31:24];
      ent_next.bytes[8] = crc_word[7:0];
      ent_next.bytes[9] = crc_word[15:8];
      ent_next.count    = last ? COUNT_SINGLE : COUNT_FIRST;
    end else begin
      ent_next.bytes[0] = s_tdata[7:0];
      ent_next.bytes[1] = s_tdata[15:8];
      ent_next.bytes[2] = s_tdata[23:16];
      ent_next.bytes[3] = s_tdata[31:24];
      ent_next.bytes[4] = crc_word[7:0];
      ent_next.bytes[5] = crc_word[15:8];
      ent_next.count    = last ? COUNT_LAST : COUNT_MIDDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_count <= '0;
      running_crc    <= CRC_INIT;
      word_index     <= '0;
      ent_valid      <= 1'b0;
    end else begin
      if (accept) begin
        ent       <= ent_next;
        ent_valid <= 1'b1;
        if (last) begin
          sequence_count <= sequence_count + 16'd1;
          running_crc    <= CRC_INIT;
          word_index     <= '0;
        end else begin
          running_crc <= crc_word;
          word_index  <= word_index + 8'd1;
        end
      end else if (ent_take) begin
        ent_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/spf_serializer.sv */
// Output stage that shifts a frame entry out one byte per cycle while the master side is ready.
module spf_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                ent_valid,
  input  spf_pkg::spf_entry_t ent,
  output logic                ent_take,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);
  import spf_pkg::*;

  logic [MaxBytes-1:0][7:0] shift_bytes;
  logic [CountWidth-1:0]    remaining;
  logic                     pkt_end;
  logic                     advance;
  logic                     slot_free;

  assign m_tvalid  = (remaining != '0);
  assign m_tdata   = shift_bytes[0];
  assign m_tlast   = (remaining == 4'd1);
  assign m_tuser   = pkt_end && (remaining == 4'd1);
  assign advance   = m_tvalid && m_tready;
  assign slot_free = (remaining == '0) || (advance && remaining == 4'd1);
  assign ent_take  = slot_free && ent_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      pkt_end   <= 1'b0;
    end else begin
      if (ent_take) begin
        shift_bytes <= ent.bytes;
        remaining   <= ent.count;
        pkt_end     <= ent.pkt_end;
      end else if (advance) begin
        shift_bytes <= shift_bytes >> 8;
        remaining   <= remaining - 4'd1;
      end
    end
  end

endmodule

/* design/sequenced_packet_framer_crc16.sv */
// Top level of the sequenced packet framer with CRC-16 trailer.
//
// The slave channel takes one 32-bit payload word per handshake. The master
// channel sends the framed byte stream, one byte per word, with tlast on the
// last byte that an input word causes and tuser on the final CRC byte of a
// packet. The first word of a packet is preceded by 0xAA, 0x55 and the
// 16-bit sequence number, low byte first; the last word of a packet is
// followed by the CRC-16 (poly 0x1021, init 0xFFFF) over sequence and
// payload bytes, low byte first.
// An accepted word is registered in the packer's entry register and then in
// the serializer's shift register before its first byte shows on the master
// side. A middle word yields 4 bytes; with the master side always ready, the
// word rate is set by the single byte lane of the output shift register.
// One frame entry is buffered behind the byte shifter, so a new word is
// taken while the previous one is still being sent. When the receiver
// stalls, the current byte holds and the slave side stops once the buffer
// is full. Reset clears the sequence number, the CRC and the word count and
// empties both stages.
module sequenced_packet_framer_crc16 #(
  parameter int unsigned WORDS_PER_PACKET = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic        m_tuser    // [0] packet_end
);
  import spf_pkg::*;

  spf_entry_t ent;
  logic       ent_valid;
  logic       ent_take;

  spf_packer #(
    .WORDS_PER_PACKET(WORDS_PER_PACKET)
  ) u_packer (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .ent_valid(ent_valid),
    .ent      (ent),
    .ent_take (ent_take)
  );

  spf_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .ent_valid(ent_valid),
    .ent      (ent),
    .ent_take (ent_take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

/* design/spf_checker.sv */
// Port-level checker for the packet framer and its bind to the top level.
module spf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("master valid after reset");

  a_user_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("packet end on a word that is not the last of its run");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled master word changed");

  a_busy_only_when_sending: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("slave side stalled while master side is idle");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |-> ##2 m_tvalid)
    else $error("accepted word did not reach the master side in two cycles");

endmodule

bind sequenced_packet_framer_crc16 spf_checker u_spf_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .m_tuser (m_tuser)
);

/* tb/testbench.sv */
// Self-checking testbench for the sequenced packet framer with CRC-16 trailer.
`timescale 1ns / 100ps

module testbench;

  localparam int WORDS_PER_PACKET = 24;
  localparam int RANDOM_WORDS     = 250;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int IDLE_PERCENT     = 8;
  localparam int STEADY_FIRST     = 100;
  localparam int STEADY_LAST      = 180;

  localparam logic [15:0] CRC_SEED   = 16'hFFFF;
  localparam logic [15:0] CRC_GEN    = 16'h1021;
  localparam logic [7:0]  HDR_FIRST  = 8'hAA;
  localparam logic [7:0]  HDR_SECOND = 8'h55;

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  typed_n;
    logic [63:0] typed;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       packet_end;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = 32'h0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  sequenced_packet_framer_crc16 #(
    .WORDS_PER_PACKET(WORDS_PER_PACKET)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  // Typed expectations are read straight off the frame layout: for a first word
  // the bytes are AA, 55, sequence low, sequence high, then the word low byte first.
  stim_row_t directed_rows [0:24] = '{
    {32'h0000_0000, 4'd8, 64'h0000_0000_0000_55AA},
    {32'hFFFF_FFFF, 4'd4, 64'h0000_0000_FFFF_FFFF},
    {32'h8000_0000, 4'd4, 64'h0000_0000_8000_0000},
    {32'h0000_0001, 4'd4, 64'h0000_0000_0000_0001},
    {32'hAAAA_5555, 4'd4, 64'h0000_0000_AAAA_5555},
    {32'h1234_5678, 4'd4, 64'h0000_0000_1234_5678},
    {32'h0000_FFFF, 4'd0, 64'h0},
    {32'hFFFF_0000, 4'd0, 64'h0},
    {32'h55AA_55AA, 4'd0, 64'h0},
    {32'hAA55_AA55, 4'd0, 64'h0},
    {32'hDEAD_BEEF, 4'd0, 64'h0},
    {32'hCAFE_F00D, 4'd0, 64'h0},
    {32'h00FF_00FF, 4'd0, 64'h0},
    {32'hFF00_FF00, 4'd0, 64'h0},
    {32'h0102_0304, 4'd0, 64'h0},
    {32'h8080_8080, 4'd0, 64'h0},
    {32'h7F7F_7F7F, 4'd0, 64'h0},
    {32'hFFFF_FFFE, 4'd0, 64'h0},
    {32'h7FFF_FFFF, 4'd0, 64'h0},
    {32'h0000_0080, 4'd0, 64'h0},
    {32'h0000_AA55, 4'd0, 64'h0},
    {32'h1357_9BDF, 4'd0, 64'h0},
    {32'h2468_ACE0, 4'd0, 64'h0},
    {32'hFFFF_FFFF, 4'd0, 64'h0},
    {32'h7FFF_FFFE, 4'd8, 64'h7FFF_FFFE_0001_55AA}
  };

  stim_row_t    words_to_send [$];
  stream_byte_t bytes_due [$];

  logic [15:0]  pkt_seq = 16'h0000;
  logic [15:0]  pkt_crc = CRC_SEED;
  logic [7:0]   pkt_words = 8'h00;
  stream_byte_t framed [0:9];
  int           framed_n;

  int  words_sent = 0;
  int  bytes_checked = 0;
  int  packets_closed = 0;
  int  mismatches = 0;
  int  cycles = 0;
  logic steady;

  assign steady = (words_sent >= STEADY_FIRST) && (words_sent < STEADY_LAST);

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      if (r[15] ^ data[i]) begin
        r = {r[14:0], 1'b0} ^ CRC_GEN;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  task automatic emit_byte(input logic [7:0] data, input logic covered);
    framed[framed_n] = '{data: data, run_end: 1'b0, packet_end: 1'b0};
    framed_n++;
    if (covered) begin
      pkt_crc = crc16_fold(pkt_crc, data);
    end
  endtask

  task automatic frame_word(input logic [31:0] value);
    logic [15:0] crc_now;
    framed_n = 0;
    if (pkt_words == 8'h00) begin
      pkt_crc = CRC_SEED;
      emit_byte(HDR_FIRST, 1'b0);
      emit_byte(HDR_SECOND, 1'b0);
      emit_byte(pkt_seq[7:0], 1'b1);
      emit_byte(pkt_seq[15:8], 1'b1);
    end
    for (int k = 0; k < 4; k++) begin
      emit_byte(value[8*k +: 8], 1'b1);
    end
    if (int'(pkt_words) + 1 >= WORDS_PER_PACKET) begin
      crc_now = pkt_crc;
      emit_byte(crc_now[7:0], 1'b0);
      emit_byte(crc_now[15:8], 1'b0);
      framed[framed_n-1].packet_end = 1'b1;
      pkt_seq = pkt_seq + 16'd1;
      pkt_crc = CRC_SEED;
      pkt_words = 8'h00;
      packets_closed++;
    end else begin
      pkt_words = pkt_words + 8'd1;
    end
    framed[framed_n-1].run_end = 1'b1;
  endtask

  always @(posedge clk) begin
    stim_row_t    row;
    stream_byte_t entry;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        row = words_to_send.pop_front();
        frame_word(row.word);
        if (row.typed_n != 4'd0) begin
          for (int k = 0; k < int'(row.typed_n); k++) begin
            entry.data = row.typed[8*k +: 8];
            entry.run_end = (k == int'(row.typed_n) - 1);
            entry.packet_end = 1'b0;
            bytes_due.push_back(entry);
          end
        end else begin
          for (int k = 0; k < framed_n; k++) begin
            bytes_due.push_back(framed[k]);
          end
        end
        words_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (words_to_send.size() != 0 &&
            (steady || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= words_to_send[0].word;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    stream_byte_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected byte %h tlast %b tuser %b", $time, m_tdata, m_tlast, m_tuser);
          mismatches++;
        end else begin
          want = bytes_due.pop_front();
          if (m_tdata !== want.data) begin
            $display("%0t: byte expected %h actual %h", $time, want.data, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.run_end) begin
            $display("%0t: tlast expected %b actual %b", $time, want.run_end, m_tlast);
            mismatches++;
          end
          if (m_tuser !== want.packet_end) begin
            $display("%0t: tuser expected %b actual %b", $time, want.packet_end, m_tuser);
            mismatches++;
          end
        end
        bytes_checked++;
      end
      m_tready <= steady || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run did not drain, %0d words and %0d bytes outstanding",
               $time, words_to_send.size(), bytes_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int        pick;
    for (int i = 0; i < 25; i++) begin
      words_to_send.push_back(directed_rows[i]);
    end
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(9, 0);
      row.typed_n = 4'd0;
      row.typed = 64'h0;
      case (pick)
        0: row.word = 32'h0000_0000;
        1: row.word = 32'hFFFF_FFFF;
        2: row.word = 32'h1 << $urandom_range(31, 0);
        3: row.word = ~(32'h1 << $urandom_range(31, 0));
        default: row.word = $urandom;
      endcase
      words_to_send.push_back(row);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (words_to_send.size() != 0 || bytes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d words framed, %0d packets closed, %0d stream bytes compared",
             words_sent, packets_closed, bytes_checked);
    $display("tb: directed frame plus random payloads, random stalls on both channels");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
